// ----- design/mst_pkg.sv -----
package mst_pkg;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [15:0] SLOW_PERIOD_RST = 16'd31249;
  localparam logic [15:0] FAST_PERIOD_RST = 16'd6249;
  localparam logic [6:0]  MAX_MINUTES_RST = 7'd60;

  localparam logic [5:0] SEC_MAX      = 6'd59;
  localparam logic [6:0] SEC_WRAP     = 7'd60;
  localparam logic [6:0] MID_STEP     = 7'd14;
  localparam logic [6:0] BIG_STEP     = 7'd59;
  localparam logic [5:0] DOWN_STEP    = 6'd14;
  localparam logic [7:0] MID_RPT_CNT  = 8'd30;
  localparam logic [7:0] BIG_RPT_CNT  = 8'd60;
  localparam logic [7:0] RPT_CNT_SAT  = 8'd255;

  typedef enum logic [1:0] {
    REG_SLOW_PERIOD = 2'd0,
    REG_FAST_PERIOD = 2'd1,
    REG_MAX_MINUTES = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    REQ_TICK   = 1'b0,
    REQ_BUTTON = 1'b1
  } req_kind_e;

  typedef enum logic [1:0] {
    BTN_NONE  = 2'd0,
    BTN_START = 2'd1,
    BTN_UP    = 2'd2,
    BTN_DOWN  = 2'd3
  } btn_e;

  typedef enum logic [2:0] {
    EV_PRESS   = 3'd1,
    EV_HOLD    = 3'd2,
    EV_RELEASE = 3'd4
  } evt_e;

  typedef struct packed {
    logic [15:0] slow_period;
    logic [15:0] fast_period;
    logic [6:0]  max_minutes;
  } cfg_t;

  typedef struct packed {
    logic       req_type;
    logic [1:0] button;
    logic [2:0] event_code;
  } req_t;

  typedef struct packed {
    logic [6:0]  minutes;
    logic [5:0]  seconds;
    logic        counting_down;
    logic        ticks_enabled;
    logic [15:0] period_value;
    logic        restart_timebase;
  } res_t;

endpackage

// ----- design/mst_if.sv -----
interface mst_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [1:0] button;
  logic [2:0] event_code;

  modport source (output valid, output req_type, output button, output event_code,
                  input ready);
  modport sink (input valid, input req_type, input button, input event_code,
                output ready);
endinterface

interface mst_res_if;
  logic        valid;
  logic        ready;
  logic [6:0]  minutes;
  logic [5:0]  seconds;
  logic        counting_down;
  logic        ticks_enabled;
  logic [15:0] period_value;
  logic        restart_timebase;

  modport source (output valid, output minutes, output seconds, output counting_down,
                  output ticks_enabled, output period_value, output restart_timebase,
                  input ready);
  modport sink (input valid, input minutes, input seconds, input counting_down,
                input ticks_enabled, input period_value, input restart_timebase,
                output ready);
endinterface

// ----- design/mst_cfg.sv -----
module mst_cfg import mst_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic [15:0] slow_q, slow_d;
  logic [15:0] fast_q, fast_d;
  logic [6:0]  maxm_q, maxm_d;
  logic        wr_en;
  cfg_reg_e    reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = cfg_reg_e'(paddr[3:2]);

  always_comb begin
    slow_d = slow_q;
    fast_d = fast_q;
    maxm_d = maxm_q;
    if (wr_en) begin
      case (reg_sel)
        REG_SLOW_PERIOD: slow_d = pwdata[15:0];
        REG_FAST_PERIOD: fast_d = pwdata[15:0];
        REG_MAX_MINUTES: maxm_d = pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SLOW_PERIOD: prdata = {16'd0, slow_q};
      REG_FAST_PERIOD: prdata = {16'd0, fast_q};
      REG_MAX_MINUTES: prdata = {25'd0, maxm_q};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slow_q <= SLOW_PERIOD_RST;
      fast_q <= FAST_PERIOD_RST;
      maxm_q <= MAX_MINUTES_RST;
    end else begin
      slow_q <= slow_d;
      fast_q <= fast_d;
      maxm_q <= maxm_d;
    end
  end

  assign cfg_o = '{slow_period: slow_q, fast_period: fast_q, max_minutes: maxm_q};

endmodule

// ----- design/mst_core.sv -----
module mst_core import mst_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic fire_i,
  input  req_t req_i,
  input  cfg_t cfg_i,
  output res_t res_o
);

  typedef struct packed {
    logic [6:0] mins;
    logic [5:0] secs;
  } mmss_t;

  logic [5:0]  sec_q, sec_d;
  logic [6:0]  min_q, min_d;
  logic        run_q, run_d;
  logic        up_rep_q, up_rep_d;
  logic        dn_rep_q, dn_rep_d;
  logic [7:0]  rep_cnt_q, rep_cnt_d;
  logic        tick_on_q, tick_on_d;
  logic [15:0] period_q, period_d;
  logic        pulse;
  mmss_t       tv;

  function automatic mmss_t step_up(mmss_t t, logic [6:0] add, logic [6:0] lim);
    mmss_t      r;
    logic [6:0] sum;
    sum = {1'b0, t.secs} + add + 7'd1;
    if (t.mins < lim) begin
      if (sum >= SEC_WRAP) begin
        r.secs = '0;
        r.mins = t.mins + 7'd1;
      end else begin
        r.secs = sum[5:0];
        r.mins = t.mins;
      end
    end else begin
      r.mins = lim;
      r.secs = '0;
    end
    return r;
  endfunction

  function automatic mmss_t step_down(mmss_t t);
    mmss_t r;
    r = t;
    if (t.secs != 6'd0 || t.mins != 7'd0) begin
      if (t.secs == 6'd0) begin
        r.mins = t.mins - 7'd1;
        r.secs = SEC_MAX;
      end else begin
        r.secs = t.secs - 6'd1;
      end
    end
    return r;
  endfunction

  // Fast down step: take 14 seconds off, then a normal decrement. A borrow
  // lands on 59 seconds, and anything below 0:00 is held at 0:00.
  function automatic mmss_t step_down_fast(mmss_t t);
    mmss_t r;
    r = t;
    if (t.secs > DOWN_STEP) begin
      r.secs = t.secs - DOWN_STEP - 6'd1;
    end else if (t.mins != 7'd0) begin
      r.mins = t.mins - 7'd1;
      r.secs = SEC_MAX;
    end else begin
      r.secs = '0;
    end
    return r;
  endfunction

  function automatic logic [7:0] bump(logic [7:0] c);
    return (c < RPT_CNT_SAT) ? c + 8'd1 : c;
  endfunction

  always_comb begin
    tv        = '{mins: min_q, secs: sec_q};
    run_d     = run_q;
    up_rep_d  = up_rep_q;
    dn_rep_d  = dn_rep_q;
    rep_cnt_d = rep_cnt_q;
    tick_on_d = tick_on_q;
    period_d  = period_q;
    pulse     = 1'b0;

    if (req_i.req_type == REQ_TICK) begin
      if (tick_on_q) begin
        // Both repeats may be active at once; they share one step count.
        if (up_rep_q) begin
          if (rep_cnt_d < MID_RPT_CNT) begin
            tv        = step_up(tv, 7'd0, cfg_i.max_minutes);
            rep_cnt_d = bump(rep_cnt_d);
          end
          if (rep_cnt_d >= MID_RPT_CNT) begin
            tv        = step_up(tv, MID_STEP, cfg_i.max_minutes);
            rep_cnt_d = bump(rep_cnt_d);
          end
          if (rep_cnt_d >= BIG_RPT_CNT) begin
            tv        = step_up(tv, BIG_STEP, cfg_i.max_minutes);
            rep_cnt_d = bump(rep_cnt_d);
          end
        end
        if (dn_rep_q) begin
          if (rep_cnt_d < MID_RPT_CNT) begin
            tv        = step_down(tv);
            rep_cnt_d = bump(rep_cnt_d);
          end
          if (rep_cnt_d >= MID_RPT_CNT) begin
            tv        = step_down_fast(tv);
            rep_cnt_d = bump(rep_cnt_d);
          end
        end
        if (run_q) begin
          tv = step_down(tv);
        end
        if (tv.secs == 6'd0 && tv.mins == 7'd0) begin
          tick_on_d = 1'b0;
          pulse     = 1'b1;
        end
      end
    end else if (!run_q) begin
      case (btn_e'(req_i.button))
        BTN_START: begin
          period_d  = cfg_i.slow_period;
          tick_on_d = 1'b1;
          run_d     = 1'b1;
          pulse     = 1'b1;
        end
        BTN_UP, BTN_DOWN: begin
          case (evt_e'(req_i.event_code))
            EV_PRESS: begin
              if (req_i.button == BTN_UP) tv = step_up(tv, 7'd0, cfg_i.max_minutes);
              else                        tv = step_down(tv);
            end
            EV_HOLD: begin
              period_d  = cfg_i.fast_period;
              tick_on_d = 1'b1;
              pulse     = 1'b1;
              if (req_i.button == BTN_UP) up_rep_d = 1'b1;
              else                        dn_rep_d = 1'b1;
            end
            EV_RELEASE: begin
              tick_on_d = 1'b0;
              pulse     = 1'b1;
              rep_cnt_d = '0;
              if (req_i.button == BTN_UP) up_rep_d = 1'b0;
              else                        dn_rep_d = 1'b0;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end else if (req_i.button == BTN_START) begin
      tick_on_d = 1'b0;
      run_d     = 1'b0;
      pulse     = 1'b1;
    end

    sec_d = tv.secs;
    min_d = tv.mins;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_q     <= '0;
      min_q     <= '0;
      run_q     <= 1'b0;
      up_rep_q  <= 1'b0;
      dn_rep_q  <= 1'b0;
      rep_cnt_q <= '0;
      tick_on_q <= 1'b0;
      period_q  <= '0;
    end else if (fire_i) begin
      sec_q     <= sec_d;
      min_q     <= min_d;
      run_q     <= run_d;
      up_rep_q  <= up_rep_d;
      dn_rep_q  <= dn_rep_d;
      rep_cnt_q <= rep_cnt_d;
      tick_on_q <= tick_on_d;
      period_q  <= period_d;
    end
  end

  assign res_o = '{minutes: min_d, seconds: sec_d, counting_down: run_d,
                   ticks_enabled: tick_on_d, period_value: period_d,
                   restart_timebase: pulse};

  a_idle_tick_keeps_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && req_i.req_type == REQ_TICK && !tick_on_q
    |=> $stable(sec_q) && $stable(min_q) && $stable(rep_cnt_q))
    else $error("tick with timebase off changed the time");

  a_idle_tick_no_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && req_i.req_type == REQ_TICK && !tick_on_q |-> !res_o.restart_timebase)
    else $error("tick with timebase off restarted the timebase");

  a_start_loads_slow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && req_i.req_type == REQ_BUTTON && req_i.button == BTN_START && !run_q
    |=> run_q && tick_on_q && period_q == $past(cfg_i.slow_period))
    else $error("start did not load the slow period");

  a_release_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && req_i.req_type == REQ_BUTTON && !run_q && req_i.event_code == EV_RELEASE &&
    (req_i.button == BTN_UP || req_i.button == BTN_DOWN)
    |=> rep_cnt_q == 8'd0 && !tick_on_q)
    else $error("release did not clear the repeat count");

endmodule

// ----- design/minute_second_countdown_timer_top.sv -----
// Minutes:seconds countdown timer.
// req_i carries one beat per timebase tick or button event; res_o returns one
// beat per request with the time after the update, the countdown and timebase
// state, the compare value for the external timebase and a restart pulse.
// Both channels are valid/ready; a beat moves when both are high.
// A request is captured in an input register, and the update logic then writes
// the result register once it is free; the result beat is driven from there.
// One request is taken every cycle while res_o drains; the rate holds because the
// time and repeat counters are updated combinationally between the two registers.
// When the receiver stalls, the result register holds and the input register
// takes one more beat, after which req_i.ready drops until the result is taken.
// Registers on the APB-style port: slow_period at 0x0, fast_period at 0x4,
// max_minutes at 0x8. Write them only while no request is in flight.
// Reset clears the time, the flags and the period register, loads the register
// defaults, and leaves both channels empty.
module minute_second_countdown_timer_top import mst_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  mst_req_if.sink           req_i,
  mst_res_if.source         res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;
  logic in_vld_q, in_vld_d;
  req_t in_q;
  logic res_vld_q, res_vld_d;
  res_t res_q, res_next;
  logic adv;
  logic in_fire;

  mst_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign adv         = in_vld_q && (!res_vld_q || res_o.ready);
  assign req_i.ready = !in_vld_q || adv;
  assign in_fire     = req_i.valid && req_i.ready;

  mst_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (adv),
    .req_i  (in_q),
    .cfg_i  (cfg),
    .res_o  (res_next)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_fire)  in_vld_d = 1'b1;
    else if (adv) in_vld_d = 1'b0;
    res_vld_d = res_vld_q;
    if (adv)              res_vld_d = 1'b1;
    else if (res_o.ready) res_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q <= '{req_type: req_i.req_type, button: req_i.button,
                event_code: req_i.event_code};
    end
    if (adv) begin
      res_q <= res_next;
    end
  end

  assign res_o.valid            = res_vld_q;
  assign res_o.minutes          = res_q.minutes;
  assign res_o.seconds          = res_q.seconds;
  assign res_o.counting_down    = res_q.counting_down;
  assign res_o.ticks_enabled    = res_q.ticks_enabled;
  assign res_o.period_value     = res_q.period_value;
  assign res_o.restart_timebase = res_q.restart_timebase;

endmodule

// ----- test/tb_minute_second_countdown_timer_top.sv -----
module tb_minute_second_countdown_timer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mst_pkg::*;

  localparam int DIR_ROWS     = 25;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 180;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 8;

  // Event codes the block does not know; used to check that they are ignored.
  localparam logic [2:0] EV_IDLE = 3'd0;
  localparam logic [2:0] EV_BAD  = 3'd3;

  // Row kinds of the directed table.
  localparam logic CHK_MODEL = 1'b0;
  localparam logic CHK_VAL   = 1'b1;

  typedef struct packed {
    req_t req;
    logic typed;
    res_t want;
  } stim_beat_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  mst_req_if req_if ();
  mst_res_if res_if ();

  minute_second_countdown_timer_top i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Rows whose result is typed in start right after reset with default registers.
  localparam stim_beat_t DIR_TAB [DIR_ROWS] = '{
    {REQ_TICK,   BTN_NONE,  EV_IDLE,    CHK_VAL, 7'd0, 6'd0, 1'b0, 1'b0, 16'd0, 1'b0},
    {REQ_BUTTON, BTN_NONE,  EV_PRESS,   CHK_VAL, 7'd0, 6'd0, 1'b0, 1'b0, 16'd0, 1'b0},
    {REQ_BUTTON, BTN_UP,    EV_IDLE,    CHK_VAL, 7'd0, 6'd0, 1'b0, 1'b0, 16'd0, 1'b0},
    {REQ_BUTTON, BTN_UP,    EV_PRESS,   CHK_VAL, 7'd0, 6'd1, 1'b0, 1'b0, 16'd0, 1'b0},
    {REQ_BUTTON, BTN_DOWN,  EV_PRESS,   CHK_VAL, 7'd0, 6'd0, 1'b0, 1'b0, 16'd0, 1'b0},
    {REQ_BUTTON, BTN_DOWN,  EV_PRESS,   CHK_VAL, 7'd0, 6'd0, 1'b0, 1'b0, 16'd0, 1'b0},
    {REQ_BUTTON, BTN_UP,    EV_HOLD,    CHK_VAL, 7'd0, 6'd0, 1'b0, 1'b1, FAST_PERIOD_RST, 1'b1},
    {REQ_TICK,   BTN_DOWN,  EV_RELEASE, CHK_VAL, 7'd0, 6'd1, 1'b0, 1'b1, FAST_PERIOD_RST, 1'b0},
    {REQ_BUTTON, BTN_UP,    EV_BAD,     CHK_VAL, 7'd0, 6'd1, 1'b0, 1'b1, FAST_PERIOD_RST, 1'b0},
    {REQ_BUTTON, BTN_UP,    EV_RELEASE, CHK_VAL, 7'd0, 6'd1, 1'b0, 1'b0, FAST_PERIOD_RST, 1'b1},
    {REQ_BUTTON, BTN_START, EV_PRESS,   CHK_VAL, 7'd0, 6'd1, 1'b1, 1'b1, SLOW_PERIOD_RST, 1'b1},
    {REQ_BUTTON, BTN_UP,    EV_PRESS,   CHK_VAL, 7'd0, 6'd1, 1'b1, 1'b1, SLOW_PERIOD_RST, 1'b0},
    {REQ_TICK,   BTN_START, EV_HOLD,    CHK_VAL, 7'd0, 6'd0, 1'b1, 1'b0, SLOW_PERIOD_RST, 1'b1},
    {REQ_TICK,   BTN_NONE,  EV_IDLE,    CHK_VAL, 7'd0, 6'd0, 1'b1, 1'b0, SLOW_PERIOD_RST, 1'b0},
    {REQ_BUTTON, BTN_START, EV_IDLE,    CHK_VAL, 7'd0, 6'd0, 1'b0, 1'b0, SLOW_PERIOD_RST, 1'b1},
    {REQ_BUTTON, BTN_DOWN,  EV_HOLD,    CHK_VAL, 7'd0, 6'd0, 1'b0, 1'b1, FAST_PERIOD_RST, 1'b1},
    {REQ_TICK,   BTN_UP,    EV_PRESS,   CHK_VAL, 7'd0, 6'd0, 1'b0, 1'b0, FAST_PERIOD_RST, 1'b1},
    {REQ_BUTTON, BTN_DOWN,  EV_RELEASE, CHK_VAL, 7'd0, 6'd0, 1'b0, 1'b0, FAST_PERIOD_RST, 1'b1},
    {REQ_BUTTON, BTN_UP,    EV_PRESS,   CHK_MODEL, 32'd0},
    {REQ_BUTTON, BTN_UP,    EV_HOLD,    CHK_MODEL, 32'd0},
    {REQ_BUTTON, BTN_DOWN,  EV_HOLD,    CHK_MODEL, 32'd0},
    {REQ_TICK,   BTN_NONE,  3'd7,       CHK_MODEL, 32'd0},
    {REQ_TICK,   BTN_DOWN,  EV_BAD,     CHK_MODEL, 32'd0},
    {REQ_BUTTON, BTN_DOWN,  EV_RELEASE, CHK_MODEL, 32'd0},
    {REQ_BUTTON, BTN_UP,    EV_RELEASE, CHK_MODEL, 32'd0}
  };

  stim_beat_t pending_beats[$];
  res_t       due_displays[$];
  int         err_cnt;
  int         res_seen;
  int         made;
  logic       steady;

  // Timer state and register copies of the predictor.
  logic [15:0] cfg_slow;
  logic [15:0] cfg_fast;
  logic [6:0]  cfg_max;
  int          st_sec;
  int          st_min;
  bit          st_run;
  bit          st_up;
  bit          st_down;
  int          st_rpt;
  bit          st_tick_on;
  logic [15:0] st_period;
  int          tm_s;
  int          tm_m;

  function automatic void count_repeat();
    if (st_rpt < int'(RPT_CNT_SAT)) st_rpt++;
  endfunction

  function automatic void step_time_up();
    if (tm_m < int'(cfg_max)) begin
      tm_s++;
      if (tm_s >= int'(SEC_WRAP)) begin
        tm_s = 0;
        tm_m++;
      end
    end else begin
      tm_m = int'(cfg_max);
      tm_s = 0;
    end
  endfunction

  function automatic void step_time_down();
    if (tm_s > 0 || tm_m > 0) begin
      tm_s--;
      if (tm_s < 0) begin
        tm_m--;
        tm_s = int'(SEC_MAX);
      end
    end
  endfunction

  function automatic res_t next_display(req_t r);
    res_t o;
    logic pulse;
    pulse = 1'b0;
    tm_s = st_sec;
    tm_m = st_min;
    if (r.req_type == REQ_TICK) begin
      if (st_tick_on) begin
        // Each repeat stage is checked against the count left by the stage before.
        if (st_up) begin
          if (st_rpt < int'(MID_RPT_CNT)) begin
            step_time_up();
            count_repeat();
          end
          if (st_rpt >= int'(MID_RPT_CNT)) begin
            tm_s += int'(MID_STEP);
            step_time_up();
            count_repeat();
          end
          if (st_rpt >= int'(BIG_RPT_CNT)) begin
            tm_s += int'(BIG_STEP);
            step_time_up();
            count_repeat();
          end
        end
        if (st_down) begin
          if (st_rpt < int'(MID_RPT_CNT)) begin
            step_time_down();
            count_repeat();
          end
          if (st_rpt >= int'(MID_RPT_CNT)) begin
            tm_s -= int'(DOWN_STEP);
            step_time_down();
            count_repeat();
            if (tm_s < 0 || tm_m < 0) begin
              tm_s = 0;
              tm_m = 0;
            end
          end
        end
        if (st_run) step_time_down();
        if (tm_s == 0 && tm_m == 0) begin
          st_tick_on = 1'b0;
          pulse = 1'b1;
        end
      end
    end else if (r.button != BTN_NONE) begin
      if (!st_run) begin
        if (r.button == BTN_START) begin
          st_period = cfg_slow;
          st_tick_on = 1'b1;
          st_run = 1'b1;
          pulse = 1'b1;
        end else if (r.event_code == EV_PRESS) begin
          if (r.button == BTN_UP) step_time_up();
          else step_time_down();
        end else if (r.event_code == EV_HOLD) begin
          st_period = cfg_fast;
          st_tick_on = 1'b1;
          pulse = 1'b1;
          if (r.button == BTN_UP) st_up = 1'b1;
          else st_down = 1'b1;
        end else if (r.event_code == EV_RELEASE) begin
          st_tick_on = 1'b0;
          pulse = 1'b1;
          st_rpt = 0;
          if (r.button == BTN_UP) st_up = 1'b0;
          else st_down = 1'b0;
        end
      end else if (r.button == BTN_START) begin
        st_tick_on = 1'b0;
        st_run = 1'b0;
        pulse = 1'b1;
      end
    end
    if (tm_s < 0) tm_s = 0;
    if (tm_s > int'(SEC_MAX)) tm_s = int'(SEC_MAX);
    if (tm_m < 0) tm_m = 0;
    if (tm_m > 127) tm_m = 127;
    st_sec = tm_s;
    st_min = tm_m;
    o.minutes = st_min[6:0];
    o.seconds = st_sec[5:0];
    o.counting_down = st_run;
    o.ticks_enabled = st_tick_on;
    o.period_value = st_period;
    o.restart_timebase = pulse;
    return o;
  endfunction

  function automatic void push_beat(logic kind, logic [1:0] btn, logic [2:0] code);
    stim_beat_t b;
    b = '0;
    b.req.req_type = kind;
    b.req.button = btn;
    b.req.event_code = code;
    b.typed = CHK_MODEL;
    pending_beats.push_back(b);
    made++;
  endfunction

  // A tick ignores button and event fields, so they carry random bits.
  function automatic void push_tick();
    push_beat(REQ_TICK, 2'($urandom_range(3)), 3'($urandom_range(7)));
  endfunction

  function automatic void gen_repeat(logic [1:0] btn, int ticks);
    push_beat(REQ_BUTTON, btn, EV_HOLD);
    repeat (ticks) push_tick();
    push_beat(REQ_BUTTON, btn, EV_RELEASE);
  endfunction

  task automatic cmp_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic apb_access(input logic wr, input cfg_reg_e idx, input logic [31:0] wdat,
                            output logic [31:0] rdat);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdat;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    rdat = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_register(cfg_reg_e idx, logic [31:0] val);
    logic [31:0] rd;
    apb_access(1'b1, idx, val, rd);
    apb_access(1'b0, idx, '0, rd);
    if (rd !== val) begin
      err_cnt++;
      $display("%0t: register %s readback, expected %0d, actual %0d", $time, idx.name(),
               val, rd);
    end
    case (idx)
      REG_SLOW_PERIOD: cfg_slow = val[15:0];
      REG_FAST_PERIOD: cfg_fast = val[15:0];
      default:         cfg_max = val[6:0];
    endcase
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_beats.size() != 0 || due_displays.size() != 0 || req_if.valid);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Alternates stretches with random gaps and stretches where both sides run flat out.
  initial begin
    steady = 1'b0;
    forever begin
      repeat ($urandom_range(900, 300)) @(posedge clk_i);
      steady <= 1'b1;
      repeat ($urandom_range(300, 120)) @(posedge clk_i);
      steady <= 1'b0;
    end
  end

  // Request side: drives beats and predicts the display for each accepted one.
  initial begin
    stim_beat_t cur;
    res_t guess;
    cur = '0;
    req_if.valid = 1'b0;
    req_if.req_type = 1'b0;
    req_if.button = 2'd0;
    req_if.event_code = 3'd0;
    forever begin
      @(posedge clk_i);
      if (req_if.valid && req_if.ready) begin
        guess = next_display(cur.req);
        due_displays.push_back(cur.typed ? cur.want : guess);
      end
      if (!req_if.valid || req_if.ready) begin
        if (rst_ni && pending_beats.size() != 0 && (steady || $urandom_range(99) >= 20)) begin
          cur = pending_beats.pop_front();
          req_if.valid <= 1'b1;
          req_if.req_type <= cur.req.req_type;
          req_if.button <= cur.req.button;
          req_if.event_code <= cur.req.event_code;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result side: checks each beat and holds off once for a long stretch.
  initial begin
    res_t got;
    res_t want;
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready) begin
        res_seen++;
        got = {res_if.minutes, res_if.seconds, res_if.counting_down, res_if.ticks_enabled,
               res_if.period_value, res_if.restart_timebase};
        if (due_displays.size() == 0) begin
          err_cnt++;
          $display("%0t: result beat with nothing expected, actual %h", $time, got);
        end else begin
          want = due_displays.pop_front();
          cmp_field("minutes", 16'(want.minutes), 16'(got.minutes));
          cmp_field("seconds", 16'(want.seconds), 16'(got.seconds));
          cmp_field("counting_down", 16'(want.counting_down), 16'(got.counting_down));
          cmp_field("ticks_enabled", 16'(want.ticks_enabled), 16'(got.ticks_enabled));
          cmp_field("period_value", want.period_value, got.period_value);
          cmp_field("restart_timebase", 16'(want.restart_timebase),
                    16'(got.restart_timebase));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (!hold_done && res_seen >= 300 && pending_beats.size() > 40) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= steady || ($urandom_range(99) >= 20);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int sel;
    int k;
    logic [15:0] sp;
    logic [15:0] fp;
    logic [6:0] mm;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    err_cnt = 0;
    res_seen = 0;
    made = 0;
    cfg_slow = SLOW_PERIOD_RST;
    cfg_fast = FAST_PERIOD_RST;
    cfg_max = MAX_MINUTES_RST;
    st_sec = 0;
    st_min = 0;
    st_run = 1'b0;
    st_up = 1'b0;
    st_down = 1'b0;
    st_rpt = 0;
    st_tick_on = 1'b0;
    st_period = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    for (int i = 0; i < DIR_ROWS; i++) pending_beats.push_back(DIR_TAB[i]);
    wait_idle();

    for (int p = 1; p <= PHASES; p++) begin
      case (p)
        1: begin sp = 16'd1; fp = 16'd1; mm = 7'd1; end
        2: begin sp = 16'hFFFF; fp = 16'hFFFF; mm = 7'd99; end
        3: begin sp = 16'd0; fp = 16'd0; mm = 7'd0; end
        4: begin sp = 16'hFFFF; fp = 16'd0; mm = 7'd127; end
        default: begin
          sp = 16'($urandom_range(16'hFFFF));
          fp = 16'($urandom_range(16'hFFFF));
          mm = 7'($urandom_range(99, 1));
        end
      endcase
      set_register(REG_SLOW_PERIOD, {16'd0, sp});
      set_register(REG_FAST_PERIOD, {16'd0, fp});
      set_register(REG_MAX_MINUTES, {25'd0, mm});
      @(negedge clk_i);
      made = 0;
      // A long up repeat runs the repeat count into saturation.
      if (p == 2) gen_repeat(BTN_UP, 262);
      while (made < PHASE_ITEMS) begin
        sel = $urandom_range(99);
        if (sel < 30) begin
          k = $urandom_range(99);
          gen_repeat($urandom_range(1) ? BTN_UP : BTN_DOWN,
                     k < 5 ? $urandom_range(270, 250) :
                     k < 30 ? $urandom_range(90, 30) : $urandom_range(29, 1));
        end else if (sel < 55) begin
          push_beat(REQ_BUTTON, BTN_START, 3'($urandom_range(7)));
          repeat ($urandom_range(70, 1)) push_tick();
          if ($urandom_range(4) != 0) push_beat(REQ_BUTTON, BTN_START, EV_PRESS);
        end else if (sel < 70) begin
          repeat ($urandom_range(6, 1))
            push_beat(REQ_BUTTON, $urandom_range(1) ? BTN_UP : BTN_DOWN, EV_PRESS);
        end else if (sel < 85) begin
          repeat ($urandom_range(4, 1))
            push_beat(1'($urandom_range(1)), 2'($urandom_range(3)), 3'($urandom_range(7)));
        end else begin
          // Overlapping or unpaired holds and releases, both repeats sharing one count.
          if ($urandom_range(1)) push_beat(REQ_BUTTON, BTN_UP, EV_HOLD);
          if ($urandom_range(1)) push_beat(REQ_BUTTON, BTN_DOWN, EV_HOLD);
          repeat ($urandom_range(80, 0)) push_tick();
          if ($urandom_range(1)) push_beat(REQ_BUTTON, BTN_DOWN, EV_RELEASE);
          if ($urandom_range(1)) push_beat(REQ_BUTTON, BTN_UP, EV_RELEASE);
        end
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/mst_pkg.sv
design/mst_if.sv
design/mst_cfg.sv
design/mst_core.sv
design/minute_second_countdown_timer_top.sv
test/tb_minute_second_countdown_timer_top.sv
